@@ rtl/ple_pkg.sv @@
package ple_pkg;

	// list geometry
	localparam int LIST_DEPTH = 128;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// first-match tree: groups of GRP cells, one registered level each
	localparam int GRP    = 16;
	localparam int GRP_W  = $clog2(GRP);
	localparam int NGRP   = (LIST_DEPTH + GRP - 1) / GRP;
	localparam int PAD_W  = NGRP * GRP;

	typedef logic signed [31:0]  data_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [GRP_W-1:0]    grp_idx_t;

	typedef enum logic [1:0] {
		FN_INSERT    = 2'd0,
		FN_DELETE    = 2'd1,
		FN_LOCATE    = 2'd2,
		FN_PARTITION = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CO_HOLD       = 2'd0,
		CO_INSERT     = 2'd1,  // cell lo takes data, cells lo+1..hi take left neighbor
		CO_SHIFT_DOWN = 2'd2   // cells lo..hi-1 take right neighbor, cell hi takes data
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     lo;
		idx_t     hi;
		data_t    data;
	} cell_cmd_t;

	// result item, status in the low bits
	typedef struct packed {
		logic [7:0] entry_count;
		logic [6:0] match_index;
		logic       found;
		status_t    status;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOC1,
		S_LOC2,
		S_LOC3,
		S_PART,
		S_EMIT
	} state_t;

endpackage

@@ rtl/ple_cell.sv @@
// One list entry. Moves data to/from its neighbors on a broadcast command.
module ple_cell (
	input  logic               clk,
	input  ple_pkg::idx_t      cell_idx,
	input  ple_pkg::cell_cmd_t cmd,
	input  ple_pkg::data_t     left_data,
	input  ple_pkg::data_t     right_data,
	input  ple_pkg::data_t     key,
	input  ple_pkg::cnt_t      count,
	output ple_pkg::data_t     entry,
	output logic               hit
);

	ple_pkg::data_t entry_q;
	ple_pkg::data_t entry_d;

	always_comb begin
		entry_d = entry_q;
		unique case (cmd.op)
			ple_pkg::CO_INSERT: begin
				if (cell_idx == cmd.lo) begin
					entry_d = cmd.data;
				end else if (cell_idx > cmd.lo && cell_idx <= cmd.hi) begin
					entry_d = left_data;
				end
			end
			ple_pkg::CO_SHIFT_DOWN: begin
				if (cell_idx == cmd.hi) begin
					entry_d = cmd.data;
				end else if (cell_idx >= cmd.lo && cell_idx < cmd.hi) begin
					entry_d = right_data;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	// only live entries may match
	assign hit   = (entry_q == key) && (ple_pkg::cnt_t'(cell_idx) < count);

endmodule

@@ rtl/ple_first_match.sv @@
// Lowest set bit of the cell hit vector, two registered levels.
module ple_first_match (
	input  logic                            clk,
	input  logic [ple_pkg::LIST_DEPTH-1:0]  match,
	output logic                            first_hit,
	output ple_pkg::idx_t                   first_idx
);

	logic [ple_pkg::PAD_W-1:0] padded;
	logic                      grp_hit_d  [ple_pkg::NGRP];
	ple_pkg::grp_idx_t         grp_idx_d  [ple_pkg::NGRP];
	logic                      grp_hit_s1 [ple_pkg::NGRP];
	ple_pkg::grp_idx_t         grp_idx_s1 [ple_pkg::NGRP];
	logic                      hit_d;
	ple_pkg::idx_t             idx_d;
	logic                      hit_s2;
	ple_pkg::idx_t             idx_s2;

	assign padded = ple_pkg::PAD_W'(match);

	// level 1: priority inside each group
	always_comb begin
		for (int g = 0; g < ple_pkg::NGRP; g++) begin
			grp_hit_d[g] = |padded[g*ple_pkg::GRP +: ple_pkg::GRP];
			grp_idx_d[g] = '0;
			for (int k = ple_pkg::GRP - 1; k >= 0; k--) begin
				if (padded[g*ple_pkg::GRP + k]) begin
					grp_idx_d[g] = ple_pkg::grp_idx_t'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_hit_s1 <= grp_hit_d;
		grp_idx_s1 <= grp_idx_d;
	end

	// level 2: priority across groups
	always_comb begin
		hit_d = 1'b0;
		idx_d = '0;
		for (int g = ple_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_hit_s1[g]) begin
				hit_d = 1'b1;
				idx_d = ple_pkg::idx_t'(g * ple_pkg::GRP + int'(grp_idx_s1[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit_d;
		idx_s2 <= idx_d;
	end

	assign first_hit = hit_s2;
	assign first_idx = idx_s2;

endmodule

@@ rtl/positional_list_engine.sv @@
// Ordered list of up to LIST_DEPTH signed 32-bit entries, held in a chain of cells
// where each cell owns one entry and trades data with its neighbors. One operation
// per transaction, one result transaction back. Insert and delete shift the chain in
// the cycle the transaction is taken, so they run one per cycle while the output
// register is free. Locate compares all cells at once and resolves the first match
// through a two-level registered tree, taking no new operation until its result is
// loaded. Partition rotates the chain one step per cycle, scanning one entry per
// step. While a result waits on m_tready, one more operation is taken, its result
// parked, and none after it until the output register frees. Status: 0 done, 1 list
// full (checked before the position), 2 bad position. found and match_index are zero
// for everything but locate. Entries beyond the count hold no defined value.
module positional_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	// operation transaction
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
	input  logic [1:0]  s_tuser,   // [1:0] func
	// result transaction
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] status, [2] found, [9:3] match_index,
	                               // [17:10] entry_count, [23:18] zero
);

	ple_pkg::state_t    state_q, state_d;
	ple_pkg::cnt_t      count_q, count_d;
	ple_pkg::idx_t      rem_q, rem_d;      // entries not yet scanned by partition
	ple_pkg::data_t     pivot_q;
	ple_pkg::data_t     key_q;
	ple_pkg::res_t      pend_q;
	ple_pkg::res_t      m_res_q;
	logic               m_tvalid_q;

	ple_pkg::cell_cmd_t cmd;
	ple_pkg::res_t      res;
	logic               done;
	logic               in_fire;
	logic               out_free;
	logic               load_out;
	logic               mover;
	ple_pkg::func_t     in_func;
	logic [7:0]         in_pos;
	ple_pkg::data_t     in_val;

	ple_pkg::data_t                 entry [ple_pkg::LIST_DEPTH];
	logic [ple_pkg::LIST_DEPTH-1:0] hit;
	logic                           tree_hit;
	ple_pkg::idx_t                  tree_idx;

	assign in_func  = ple_pkg::func_t'(s_tuser);
	assign in_pos   = s_tdata[7:0];
	assign in_val   = s_tdata[39:8];
	assign s_tready = (state_q == ple_pkg::S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign mover    = entry[0] < pivot_q;

	// cell chain
	for (genvar i = 0; i < ple_pkg::LIST_DEPTH; i++) begin : g_cell
		ple_pkg::data_t left_data;
		ple_pkg::data_t right_data;
		if (i == 0) begin : g_first
			assign left_data = entry[0];
		end else begin : g_left
			assign left_data = entry[i-1];
		end
		if (i == ple_pkg::LIST_DEPTH - 1) begin : g_last
			assign right_data = entry[i];
		end else begin : g_right
			assign right_data = entry[i+1];
		end
		ple_cell u_cell (
			.clk        (clk),
			.cell_idx   (ple_pkg::idx_t'(i)),
			.cmd        (cmd),
			.left_data  (left_data),
			.right_data (right_data),
			.key        (key_q),
			.count      (count_q),
			.entry      (entry[i]),
			.hit        (hit[i])
		);
	end

	ple_first_match u_first_match (
		.clk       (clk),
		.match     (hit),
		.first_hit (tree_hit),
		.first_idx (tree_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (in_fire) begin
					if (in_func == ple_pkg::FN_LOCATE) begin
						state_d = ple_pkg::S_LOC1;
					end else if (in_func == ple_pkg::FN_PARTITION &&
					             count_q > ple_pkg::cnt_t'(1)) begin
						state_d = ple_pkg::S_PART;
					end else if (!out_free) begin
						state_d = ple_pkg::S_EMIT;
					end
				end
			end
			ple_pkg::S_LOC1: state_d = ple_pkg::S_LOC2;
			ple_pkg::S_LOC2: state_d = ple_pkg::S_LOC3;
			ple_pkg::S_LOC3: state_d = out_free ? ple_pkg::S_IDLE : ple_pkg::S_EMIT;
			ple_pkg::S_PART: begin
				if (rem_q == ple_pkg::idx_t'(1)) begin
					state_d = out_free ? ple_pkg::S_IDLE : ple_pkg::S_EMIT;
				end
			end
			ple_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = ple_pkg::S_IDLE;
				end
			end
			default: state_d = ple_pkg::S_IDLE;
		endcase
	end

	// chain command, result, count
	always_comb begin
		cmd      = '{op: ple_pkg::CO_HOLD, lo: '0, hi: '0, data: entry[0]};
		done     = 1'b0;
		count_d  = count_q;
		rem_d    = rem_q;
		res      = '{entry_count: 8'(count_q), match_index: '0, found: 1'b0,
		             status: ple_pkg::STAT_DONE};
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (in_fire) begin
					unique case (in_func)
						ple_pkg::FN_INSERT: begin
							done = 1'b1;
							if (count_q >= ple_pkg::cnt_t'(ple_pkg::LIST_DEPTH)) begin
								res.status = ple_pkg::STAT_FULL;
							end else if (in_pos == 8'd0 ||
							             9'(in_pos) > 9'(count_q) + 9'd1) begin
								res.status = ple_pkg::STAT_BADPOS;
							end else begin
								cmd.op   = ple_pkg::CO_INSERT;
								cmd.lo   = ple_pkg::idx_t'(in_pos - 8'd1);
								cmd.hi   = ple_pkg::idx_t'(count_q);
								cmd.data = in_val;
								count_d  = count_q + ple_pkg::cnt_t'(1);
							end
						end
						ple_pkg::FN_DELETE: begin
							done = 1'b1;
							if (in_pos == 8'd0 || 9'(in_pos) > 9'(count_q)) begin
								res.status = ple_pkg::STAT_BADPOS;
							end else begin
								cmd.op  = ple_pkg::CO_SHIFT_DOWN;
								cmd.lo  = ple_pkg::idx_t'(in_pos - 8'd1);
								cmd.hi  = ple_pkg::idx_t'(count_q - ple_pkg::cnt_t'(1));
								count_d = count_q - ple_pkg::cnt_t'(1);
							end
						end
						ple_pkg::FN_LOCATE: begin
							done = 1'b0;
						end
						ple_pkg::FN_PARTITION: begin
							// first step parks the pivot at the top of the live range
							if (count_q == '0) begin
								done = 1'b1;
							end else begin
								cmd.op = ple_pkg::CO_SHIFT_DOWN;
								cmd.hi = ple_pkg::idx_t'(count_q - ple_pkg::cnt_t'(1));
								if (count_q == ple_pkg::cnt_t'(1)) begin
									done = 1'b1;
								end else begin
									rem_d = ple_pkg::idx_t'(count_q - ple_pkg::cnt_t'(1));
								end
							end
						end
						default: done = 1'b0;
					endcase
					res.entry_count = 8'(count_d);
				end
			end
			ple_pkg::S_LOC3: begin
				done              = 1'b1;
				res.found         = tree_hit;
				res.match_index   = tree_hit ? 7'(tree_idx) : 7'd0;
			end
			ple_pkg::S_PART: begin
				// smaller entry goes just below the unscanned run, others to the top
				cmd.op = ple_pkg::CO_SHIFT_DOWN;
				cmd.hi = mover ? rem_q - ple_pkg::idx_t'(1)
				               : ple_pkg::idx_t'(count_q - ple_pkg::cnt_t'(1));
				rem_d  = rem_q - ple_pkg::idx_t'(1);
				if (rem_q == ple_pkg::idx_t'(1)) begin
					done = 1'b1;
				end
			end
			default: done = 1'b0;
		endcase
	end

	assign load_out = out_free && (done || state_q == ple_pkg::S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ple_pkg::S_IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_func == ple_pkg::FN_LOCATE) begin
			key_q <= in_val;
		end
		if (in_fire && in_func == ple_pkg::FN_PARTITION) begin
			pivot_q <= entry[0];
		end
		if (done && !out_free) begin
			pend_q <= res;
		end
		if (load_out) begin
			m_res_q <= done ? res : pend_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_res_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ple_pkg::cnt_t'(ple_pkg::LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_part_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ple_pkg::S_PART |->
			rem_q != '0 && ple_pkg::cnt_t'(rem_q) < count_q)
		else $error("partition scan counter out of the live range");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ple_pkg::S_EMIT |-> m_tvalid_q)
		else $error("result parked while output register is empty");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> m_res_q.entry_count == 8'(count_q))
		else $error("reported entry count differs from list count");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_res_q.found |-> m_res_q.status == ple_pkg::STAT_DONE)
		else $error("match reported with an error status");
`endif

endmodule

@@ dv/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps

module tb_positional_list_engine;

	localparam int N_RANDOM  = 600;
	localparam int MAX_SHOWN = 10;

	// one directed row: operation plus, where typed, the expected result
	typedef struct packed {
		ple_pkg::func_t fn;
		logic [7:0]     pos;
		ple_pkg::data_t val;
		logic           typed;
		ple_pkg::res_t  want;
	} op_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	// shadow of the list contents and length
	ple_pkg::data_t list_mem [ple_pkg::LIST_DEPTH];
	int             list_len;

	ple_pkg::res_t pending_res [$];
	op_row_t       op_plan [$];
	int            err_count;
	int            n_rand;
	int            tx_burst;

	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	positional_list_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// applies one operation to the shadow list, returns the result it should give
	function automatic ple_pkg::res_t apply_op(ple_pkg::func_t fn, logic [7:0] pos,
		ple_pkg::data_t val);
		ple_pkg::res_t  r;
		ple_pkg::data_t pivot;
		ple_pkg::data_t mover;
		int             p;
		r = '0;
		r.status = ple_pkg::STAT_DONE;
		p = int'(pos);
		case (fn)
			ple_pkg::FN_INSERT: begin
				if (list_len >= ple_pkg::LIST_DEPTH) begin
					r.status = ple_pkg::STAT_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ple_pkg::STAT_BADPOS;
				end else begin
					for (int j = list_len; j >= p; j--)
						list_mem[j] = list_mem[j-1];
					list_mem[p-1] = val;
					list_len++;
				end
			end
			ple_pkg::FN_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ple_pkg::STAT_BADPOS;
				end else begin
					for (int j = p; j < list_len; j++)
						list_mem[j-1] = list_mem[j];
					list_len--;
				end
			end
			ple_pkg::FN_LOCATE: begin
				for (int j = 0; j < list_len; j++) begin
					if (!r.found && list_mem[j] == val) begin
						r.found = 1'b1;
						r.match_index = j[6:0];
					end
				end
			end
			default: begin
				// smaller entries hop to the front one by one, last mover ends up first
				if (list_len > 0) begin
					pivot = list_mem[0];
					for (int i = 1; i < list_len; i++) begin
						if (list_mem[i] < pivot) begin
							mover = list_mem[i];
							for (int j = i; j > 0; j--)
								list_mem[j] = list_mem[j-1];
							list_mem[0] = mover;
						end
					end
				end
			end
		endcase
		r.entry_count = list_len[7:0];
		return r;
	endfunction

	function automatic op_row_t mk_row(ple_pkg::func_t fn, int pos, ple_pkg::data_t val,
		bit typed, ple_pkg::status_t st, bit fnd, int idx, int cnt);
		op_row_t row;
		row.fn = fn;
		row.pos = pos[7:0];
		row.val = val;
		row.typed = typed;
		row.want = '0;
		row.want.status = st;
		row.want.found = fnd;
		row.want.match_index = idx[6:0];
		row.want.entry_count = cnt[7:0];
		return row;
	endfunction

	function automatic ple_pkg::data_t pick_value();
		ple_pkg::data_t v;
		case ($urandom_range(0, 7))
			0, 1: v = ple_pkg::data_t'($urandom_range(0, 6)) - 32'sd3;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7FFFFFFF;
					1: v = 32'sh80000000;
					2: v = 32'sh0;
					default: v = -32'sd1;
				endcase
			end
			default: v = ple_pkg::data_t'($urandom);
		endcase
		return v;
	endfunction

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_op(op_row_t row);
		ple_pkg::res_t want;
		int            gap;
		if (tx_burst == 0) begin
			tx_burst = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		tx_burst--;
		s_tvalid <= 1'b1;
		s_tdata <= {row.val, row.pos};
		s_tuser <= row.fn;
		do @(posedge clk); while (!s_tready);
		want = apply_op(row.fn, row.pos, row.val);
		pending_res.push_back(row.typed ? row.want : want);
		@(negedge clk);
	endtask

	// weighted random operation; bad_pct is the share of unconstrained positions
	task automatic rand_op(int w_ins, int w_del, int w_loc, int w_part, int bad_pct);
		op_row_t row;
		int      pick;
		pick = $urandom_range(0, w_ins + w_del + w_loc + w_part - 1);
		row = mk_row(ple_pkg::FN_PARTITION, 0, pick_value(), 1'b0, ple_pkg::STAT_DONE,
			1'b0, 0, 0);
		row.pos = 8'($urandom_range(0, 255));
		if (pick < w_ins) begin
			row.fn = ple_pkg::FN_INSERT;
			if ($urandom_range(0, 99) >= bad_pct && list_len < ple_pkg::LIST_DEPTH)
				row.pos = 8'($urandom_range(1, list_len + 1));
		end else if (pick < w_ins + w_del) begin
			row.fn = ple_pkg::FN_DELETE;
			if ($urandom_range(0, 99) >= bad_pct && list_len > 0)
				row.pos = 8'($urandom_range(1, list_len));
		end else if (pick < w_ins + w_del + w_loc) begin
			row.fn = ple_pkg::FN_LOCATE;
			if (list_len > 0 && $urandom_range(0, 1) == 1)
				row.val = list_mem[$urandom_range(0, list_len - 1)];
		end
		send_op(row);
		n_rand++;
	endtask

	task automatic noise_op();
		op_row_t row;
		row = mk_row(ple_pkg::func_t'($urandom_range(0, 3)), $urandom_range(0, 255),
			ple_pkg::data_t'($urandom), 1'b0, ple_pkg::STAT_DONE, 1'b0, 0, 0);
		send_op(row);
		n_rand++;
	endtask

	// receiver: m_tready mode switches at random among four patterns
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_tick % 11) < 4;
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		ple_pkg::res_t got;
		ple_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[17:0];
			if (pending_res.size() == 0) begin
				err_count++;
				if (err_count <= MAX_SHOWN)
					$display("%0t: unexpected result 0x%06h", $realtime, m_tdata);
			end else begin
				want = pending_res.pop_front();
				if (got.status !== want.status || got.found !== want.found ||
					got.match_index !== want.match_index ||
					got.entry_count !== want.entry_count || m_tdata[23:18] !== 6'd0) begin
					err_count++;
					// fields in order status/found/index/count
					if (err_count <= MAX_SHOWN)
						$display("%0t: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad %0h",
							$realtime, want.status, want.found, want.match_index,
							want.entry_count, got.status, got.found, got.match_index,
							got.entry_count, m_tdata[23:18]);
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		err_count = 0;
		n_rand = 0;
		tx_burst = 0;
		list_len = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list corner cases
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sd0, 1,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_DELETE, 1, 32'sd0, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_PARTITION, 0, 32'sd0, 1,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 0, 32'sd5, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 2, 32'sd5, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 0));
		// list becomes MIN, MAX, 0
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 1, 32'sh7FFFFFFF, 1,
			ple_pkg::STAT_DONE, 0, 0, 1));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 1, 32'sh80000000, 1,
			ple_pkg::STAT_DONE, 0, 0, 2));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 3, 32'sd0, 1,
			ple_pkg::STAT_DONE, 0, 0, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 255, -32'sd1, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sh80000000, 1,
			ple_pkg::STAT_DONE, 1, 0, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sd0, 1,
			ple_pkg::STAT_DONE, 1, 2, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 9, 32'sh7FFFFFFF, 1,
			ple_pkg::STAT_DONE, 1, 1, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, -32'sd1, 1,
			ple_pkg::STAT_DONE, 0, 0, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_DELETE, 0, 32'sd0, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 3));
		op_plan.push_back(mk_row(ple_pkg::FN_DELETE, 4, 32'sd0, 1,
			ple_pkg::STAT_BADPOS, 0, 0, 3));
		// list becomes 0, MIN, -1, MAX, 0 with a duplicate
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 2, -32'sd1, 1,
			ple_pkg::STAT_DONE, 0, 0, 4));
		op_plan.push_back(mk_row(ple_pkg::FN_INSERT, 1, 32'sd0, 1,
			ple_pkg::STAT_DONE, 0, 0, 5));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sd0, 1,
			ple_pkg::STAT_DONE, 1, 0, 5));
		op_plan.push_back(mk_row(ple_pkg::FN_PARTITION, 0, 32'sd0, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sd0, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_LOCATE, 0, 32'sh80000000, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_DELETE, 5, 32'sd0, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_DELETE, 1, 32'sd0, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		op_plan.push_back(mk_row(ple_pkg::FN_PARTITION, 0, 32'sd0, 0,
			ple_pkg::STAT_DONE, 0, 0, 0));
		foreach (op_plan[i])
			send_op(op_plan[i]);

		// grow, fill to the brim, poke the full list, then drain it completely
		repeat (80) rand_op(6, 1, 2, 1, 10);
		while (list_len < ple_pkg::LIST_DEPTH)
			rand_op(1, 0, 0, 0, 10);
		repeat (16) rand_op(4, 0, 2, 1, 50);
		while (list_len > 0)
			rand_op(1, 6, 2, 1, 10);
		repeat (6) rand_op(1, 2, 1, 1, 20);

		while (n_rand < N_RANDOM) begin
			case ($urandom_range(0, 3))
				0: repeat (40) rand_op(3, 3, 2, 1, 10);
				1: repeat (40) rand_op(6, 2, 2, 1, 10);
				2: repeat (40) rand_op(2, 6, 2, 1, 10);
				default: repeat (20) noise_op();
			endcase
		end

		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (err_count == 0 && pending_res.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
